// ----- hw/rtl/ssds_pkg.sv -----
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared types, constants and the sequencer program of the surround delay.
// ----------------------------------------------------------------------------
package ssds_pkg;

  localparam int SampleW      = 32;
  localparam int CoefW        = 16;
  localparam int StoreW       = 24;
  localparam int LenW         = 13;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 16;
  localparam int DelayDepthDef = 4096;
  localparam int LenReset     = 441;

  localparam int MidRound = 256;
  localparam int MidShift = 9;
  localparam int HpShift  = 10;
  localparam int LpShift  = 10 - 8;
  localparam int FbShift  = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDelayLen  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHpFb      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHpIn      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHpPrevIn  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLpFb      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLpIn      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLpPrevIn  = 3'd6;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  // Program steps
  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;
  localparam step_t StepClear = 4'd0;
  localparam step_t StepIdle  = 4'd1;
  localparam step_t StepHpIn  = 4'd2;
  localparam step_t StepHpPi  = 4'd3;
  localparam step_t StepHpFb  = 4'd4;
  localparam step_t StepLpIn  = 4'd5;
  localparam step_t StepLpPi  = 4'd6;
  localparam step_t StepLpFb  = 4'd7;
  localparam step_t StepDone  = 4'd8;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_IN       = 2'd1,
    COND_OUT_FREE = 2'd2,
    COND_CLR_LAST = 2'd3
  } cond_e;

  typedef enum logic [2:0] {
    MA_HP_IN = 3'd0,
    MA_HP_PI = 3'd1,
    MA_HP_FB = 3'd2,
    MA_LP_IN = 3'd3,
    MA_LP_PI = 3'd4,
    MA_LP_FB = 3'd5
  } mula_e;

  typedef enum logic [2:0] {
    MB_ECHO        = 3'd0,
    MB_HP_PREV_IN  = 3'd1,
    MB_HP_PREV_OUT = 3'd2,
    MB_HP_NOW      = 3'd3,
    MB_LP_PREV_OUT = 3'd4
  } mulb_e;

  typedef struct packed {
    cond_e  cond;      // hold the step until this holds
    logic   jump;
    step_t  target;
    mula_e  mul_a;
    mulb_e  mul_b;
    logic   acc_en;
    logic   acc_clr;
    logic   latch_in;  // take the input beat, issue the delay read
    logic   wr_clr;    // write zero at the position (clearing pass)
    logic   wr_mid;    // write the mid sample, capture the echo
    logic   hpi_ld;
    logic   hpcur_ld;
    logic   hpo_ld;
    logic   finish;    // load output, feedback and position
  } ctrl_t;

  function automatic ctrl_t ctrl_rom(step_t step);
    ctrl_t c;
    c        = '0;
    c.cond   = COND_ALWAYS;
    c.mul_a  = MA_HP_IN;
    c.mul_b  = MB_ECHO;
    c.target = StepIdle;
    unique case (step)
      StepClear: begin
        c.cond   = COND_CLR_LAST;
        c.wr_clr = 1'b1;
      end
      StepIdle: begin
        c.cond     = COND_IN;
        c.latch_in = 1'b1;
      end
      StepHpIn: begin
        c.wr_mid  = 1'b1;
        c.acc_en  = 1'b1;
        c.acc_clr = 1'b1;
      end
      StepHpPi: begin
        c.mul_a  = MA_HP_PI;
        c.mul_b  = MB_HP_PREV_IN;
        c.acc_en = 1'b1;
        c.hpi_ld = 1'b1;
      end
      StepHpFb: begin
        c.mul_a  = MA_HP_FB;
        c.mul_b  = MB_HP_PREV_OUT;
        c.acc_en = 1'b1;
      end
      StepLpIn: begin
        c.mul_a    = MA_LP_IN;
        c.mul_b    = MB_HP_NOW;
        c.acc_en   = 1'b1;
        c.acc_clr  = 1'b1;
        c.hpcur_ld = 1'b1;
      end
      StepLpPi: begin
        c.mul_a  = MA_LP_PI;
        c.mul_b  = MB_HP_PREV_OUT;
        c.acc_en = 1'b1;
        c.hpo_ld = 1'b1;
      end
      StepLpFb: begin
        c.mul_a  = MA_LP_FB;
        c.mul_b  = MB_LP_PREV_OUT;
        c.acc_en = 1'b1;
      end
      StepDone: begin
        c.cond   = COND_OUT_FREE;
        c.finish = 1'b1;
        c.jump   = 1'b1;
      end
      default: begin
        c.jump = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/ssds_in_if.sv -----
// ----------------------------------------------------------------------------
// ssds_in_if
// Input frame channel: valid/ready with a stereo sample pair.
// ----------------------------------------------------------------------------
interface ssds_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_in;
  logic signed [31:0] right_in;
  logic               block_end;

  modport source (output valid, left_in, right_in, block_end, input ready);
  modport sink   (input valid, left_in, right_in, block_end, output ready);
endinterface

// ----- hw/rtl/ssds_out_if.sv -----
// ----------------------------------------------------------------------------
// ssds_out_if
// Output frame channel: valid/ready with the processed stereo pair.
// ----------------------------------------------------------------------------
interface ssds_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_out;
  logic signed [31:0] right_out;
  logic               block_end_out;

  modport source (output valid, left_out, right_out, block_end_out, input ready);
  modport sink   (input valid, left_out, right_out, block_end_out, output ready);
endinterface

// ----- hw/rtl/ssds_ram.sv -----
// ----------------------------------------------------------------------------
// ssds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssds_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/stereo_surround_delay_shelf.sv -----
// ----------------------------------------------------------------------------
// stereo_surround_delay_shelf
// Pseudo-surround: delayed mid signal through a high-pass and a low-pass
// first-order section, added to left and subtracted from right.
// ----------------------------------------------------------------------------
// Use:
//   in_i   - sink of stereo frames (left_in, right_in, block_end).
//   out_o  - source of processed frames (left_out, right_out, block_end_out),
//            one per input beat, in order.
//   cfg_*  - write-only register port; write only while no frame is in
//            flight. Index 0 is the delay length, 1..6 the filter coefficients.
// Timing: a microcoded sequencer steps one shared 32x32 multiplier through the
//   six products of the two sections. After the accept step, the six multiply
//   steps run and the finish step then loads the output register; the next
//   frame is accepted only after that finish, so one frame is in the
//   sequencer at a time.
// Reset: the program starts with a clearing pass that zeroes all DELAY_DEPTH
//   slots of the delay RAM one slot per cycle, during which in_i.ready is low.
//   Registers take their reset values at once and may be written meanwhile.
// Stall: the result waits in the output register; the sequencer may take and
//   compute the next frame but holds at its finish step until the output
//   register is free.
// ----------------------------------------------------------------------------
module stereo_surround_delay_shelf #(
  parameter int DELAY_DEPTH = ssds_pkg::DelayDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ssds_pkg::CfgDataW-1:0] cfg_data_i,
  ssds_in_if.sink                       in_i,
  ssds_out_if.source                    out_o
);

  import ssds_pkg::*;

  localparam int PosW = $clog2(DELAY_DEPTH);
  localparam int CmpW = (PosW + 1 > LenW) ? PosW + 1 : LenW;

  // Configuration registers
  logic [LenW-1:0] delay_len_q;
  coef_t hp_fb_q, hp_in_q, hp_pi_q, lp_fb_q, lp_in_q, lp_pi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= LenW'(LenReset);
      hp_fb_q     <= '0;
      hp_in_q     <= '0;
      hp_pi_q     <= '0;
      lp_fb_q     <= '0;
      lp_in_q     <= '0;
      lp_pi_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDelayLen: delay_len_q <= cfg_data_i[LenW-1:0];
        RegHpFb:     hp_fb_q     <= cfg_data_i;
        RegHpIn:     hp_in_q     <= cfg_data_i;
        RegHpPrevIn: hp_pi_q     <= cfg_data_i;
        RegLpFb:     lp_fb_q     <= cfg_data_i;
        RegLpIn:     lp_in_q     <= cfg_data_i;
        RegLpPrevIn: lp_pi_q     <= cfg_data_i;
        default: ;  // unused index
      endcase
    end
  end

  // Sequencer
  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  go;
  logic  out_free;
  logic [PosW-1:0] pos_q, pos_d;
  logic  clr_last;

  assign ctrl     = ctrl_rom(step_q);
  assign out_free = !out_o.valid || out_o.ready;
  assign clr_last = (pos_q == PosW'(DELAY_DEPTH - 1));

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:   go = 1'b1;
      COND_IN:       go = in_i.valid;
      COND_OUT_FREE: go = out_free;
      COND_CLR_LAST: go = clr_last;
      default:       go = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = ctrl.jump ? ctrl.target : step_q + 1'b1;
    end
  end

  assign in_i.ready = (step_q == StepIdle);

  // Datapath registers
  sample_t left_q, right_q;
  logic    end_q;
  sample_t acc_q, acc_d;
  sample_t hp_cur_q, hp_prev_out_q, lp_prev_out_q;
  logic signed [StoreW-1:0] echo_q, hp_prev_in_q;

  logic [StoreW-1:0] ram_rdata;
  logic [StoreW-1:0] ram_wdata;
  sample_t mid_sum;
  sample_t echo_ext;
  sample_t hp_now;
  sample_t mul_a, mul_b, prod;
  sample_t v;

  assign mid_sum   = left_q + right_q + SampleW'(MidRound);
  assign ram_wdata = ctrl.wr_clr ? '0 : StoreW'(mid_sum >>> MidShift);
  assign echo_ext  = SampleW'($signed(ram_rdata));
  assign hp_now    = acc_q >>> HpShift;
  assign v         = acc_q >>> LpShift;

  ssds_ram #(
    .Width (StoreW),
    .Depth (DELAY_DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.wr_clr || ctrl.wr_mid),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .re_i    (ctrl.latch_in && go),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier operand selection; the product keeps the low 32 bits
  always_comb begin
    unique case (ctrl.mul_a)
      MA_HP_IN: mul_a = SampleW'(hp_in_q);
      MA_HP_PI: mul_a = SampleW'(hp_pi_q);
      MA_HP_FB: mul_a = SampleW'(hp_fb_q);
      MA_LP_IN: mul_a = SampleW'(lp_in_q);
      MA_LP_PI: mul_a = SampleW'(lp_pi_q);
      MA_LP_FB: mul_a = SampleW'(lp_fb_q);
      default:  mul_a = '0;
    endcase
    unique case (ctrl.mul_b)
      MB_ECHO:        mul_b = echo_ext;
      MB_HP_PREV_IN:  mul_b = SampleW'(hp_prev_in_q);
      MB_HP_PREV_OUT: mul_b = hp_prev_out_q;
      MB_HP_NOW:      mul_b = hp_now;
      MB_LP_PREV_OUT: mul_b = lp_prev_out_q;
      default:        mul_b = '0;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign acc_d = (ctrl.acc_clr ? '0 : acc_q) + prod;

  // Position: advance and wrap against the clamped length
  logic [CmpW-1:0] pos_inc, len_eff;

  always_comb begin
    pos_inc = CmpW'(pos_q) + 1'b1;
    len_eff = (CmpW'(delay_len_q) > CmpW'(DELAY_DEPTH)) ? CmpW'(DELAY_DEPTH)
                                                         : CmpW'(delay_len_q);
    pos_d = pos_q;
    if (ctrl.wr_clr) begin
      pos_d = clr_last ? '0 : pos_inc[PosW-1:0];
    end else if (ctrl.finish && go) begin
      pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= StepClear;
      pos_q         <= '0;
      hp_prev_in_q  <= '0;
      hp_prev_out_q <= '0;
      lp_prev_out_q <= '0;
      out_o.valid   <= 1'b0;
    end else begin
      step_q <= step_d;
      pos_q  <= pos_d;
      if (ctrl.hpi_ld) begin
        hp_prev_in_q <= echo_q;
      end
      if (ctrl.hpo_ld) begin
        hp_prev_out_q <= hp_cur_q;
      end
      if (ctrl.finish && go) begin
        lp_prev_out_q <= v >>> FbShift;
        out_o.valid   <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl.latch_in && go) begin
      left_q  <= in_i.left_in;
      right_q <= in_i.right_in;
      end_q   <= in_i.block_end;
    end
    if (ctrl.wr_mid) begin
      echo_q <= ram_rdata;
    end
    if (ctrl.acc_en) begin
      acc_q <= acc_d;
    end
    if (ctrl.hpcur_ld) begin
      hp_cur_q <= hp_now;
    end
    if (ctrl.finish && go) begin
      out_o.left_out      <= left_q + v;
      out_o.right_out     <= right_q - v;
      out_o.block_end_out <= end_q;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_surround_delay_shelf. Stereo frames go in on
// a bursty valid/ready channel and the processed frames are compared, field by
// field and in order, against a behavioural model of the delay line and the two
// shelving sections. The receiver stalls on a pattern of its own. Registers are
// rewritten between phases, covering zero and saturated lengths, a length cut
// below the current position, extreme coefficients and the unused index.
// ----------------------------------------------------------------------------
module tb_top;
  import ssds_pkg::*;

  localparam int DelayDepth = DelayDepthDef;
  // Index 7 decodes to nothing in the block
  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;
  // Covers the clearing pass, the long receiver hold-off and the worst gaps
  localparam int WatchdogLimit = 4 * (DelayDepth + 400);
  localparam int HoldOffCycles = 300;
  localparam int HoldOffAfter  = 400;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    block_end;
  } frame_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RxOpen   = 2'd0,  // always ready
    RxCoin   = 2'd1,  // ready half the time
    RxSparse = 2'd2,  // ready one cycle in four
    RxPulse  = 2'd3   // regular ready/stall rhythm
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ssds_in_if  in_if ();
  ssds_out_if out_if ();

  stereo_surround_delay_shelf dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Surround model: mirror of the register file and the filter state
  // --------------------------------------------------------------------------
  logic [LenW-1:0] cfg_len = LenW'(LenReset);
  coef_t k_hp_fb = '0;
  coef_t k_hp_in = '0;
  coef_t k_hp_pi = '0;
  coef_t k_lp_fb = '0;
  coef_t k_lp_in = '0;
  coef_t k_lp_pi = '0;

  sample_t     mid_line [DelayDepth];  // cleared in the initial block
  int unsigned line_pos    = 0;
  sample_t     hp_last_in  = '0;       // previous delayed mid sample
  sample_t     hp_last_out = '0;       // previous high-pass output
  sample_t     lp_last_fb  = '0;       // previous low-pass output >>> 8

  frame_t frames_to_send [$];
  frame_t awaited_frames [$];

  int mismatch_count = 0;
  int frames_seen    = 0;
  logic in_beat = 1'b0;  // input beat taken at the last rising edge

  // One frame through the delay and both sections; all sums wrap at 32 bits
  function automatic frame_t surround_frame(frame_t f);
    sample_t     echo;
    sample_t     hp;
    sample_t     v;
    sample_t     acc;
    int unsigned len;
    int unsigned pos;
    frame_t      r;
    len = (cfg_len > DelayDepth) ? DelayDepth : cfg_len;
    pos = line_pos % DelayDepth;
    // read before write: the slot holds the mid sample from len frames back
    echo          = mid_line[pos];
    mid_line[pos] = (f.left + f.right + 32'sd256) >>> MidShift;

    acc        = k_hp_in * echo + k_hp_pi * hp_last_in + k_hp_fb * hp_last_out;
    hp         = acc >>> HpShift;
    hp_last_in = echo;

    acc         = k_lp_in * hp + k_lp_pi * hp_last_out + k_lp_fb * lp_last_fb;
    v           = acc >>> LpShift;
    hp_last_out = hp;
    lp_last_fb  = v >>> FbShift;

    // zero length behaves as one: the position never leaves slot 0
    pos++;
    if (pos >= len) pos = 0;
    line_pos = pos;

    r.left      = f.left + v;
    r.right     = f.right - v;
    r.block_end = f.block_end;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_t got;
    frame_t want;
    in_beat <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        got.left      = in_if.left_in;
        got.right     = in_if.right_in;
        got.block_end = in_if.block_end;
        awaited_frames.push_back(surround_frame(got));
      end
      if (out_if.valid && out_if.ready) begin
        frames_seen++;
        if (awaited_frames.size() == 0) begin
          report_mismatch("output beat with no frame awaited");
        end else begin
          want = awaited_frames.pop_front();
          if (out_if.left_out !== want.left)
            report_mismatch($sformatf("frame %0d left_out %h, wanted %h",
                                      frames_seen, out_if.left_out, want.left));
          if (out_if.right_out !== want.right)
            report_mismatch($sformatf("frame %0d right_out %h, wanted %h",
                                      frames_seen, out_if.right_out, want.right));
          if (out_if.block_end_out !== want.block_end)
            report_mismatch($sformatf("frame %0d block_end_out %b, wanted %b",
                                      frames_seen, out_if.block_end_out,
                                      want.block_end));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them. A beat that is
  // offered stays up until it is taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    frame_t f;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_beat) begin
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (frames_to_send.size() != 0) begin
        f = frames_to_send.pop_front();
        in_if.left_in   <= f.left;
        in_if.right_in  <= f.right;
        in_if.block_end <= f.block_end;
        in_if.valid     <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of bursts run straight into the next one
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: the stall pattern is redrawn at random. Once, after a few
  // hundred frames, ready is held low long enough for the block to back up
  // and drop its input ready while the driver keeps offering.
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode      = RxOpen;
  int       rx_mode_left = 0;
  int       rx_phase     = 0;
  int       hold_left    = 0;
  logic     hold_done    = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && frames_seen >= HoldOffAfter) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(8, 80);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RxOpen:   out_if.ready <= 1'b1;
        RxCoin:   out_if.ready <= 1'($urandom_range(0, 1));
        RxSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:  out_if.ready <= (rx_phase % 5 < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any beat on either channel
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Register write; the model copy is updated at once since nothing is in flight
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDelayLen: cfg_len = data[LenW-1:0];  // upper data bits dropped
      RegHpFb:     k_hp_fb = data;
      RegHpIn:     k_hp_in = data;
      RegHpPrevIn: k_hp_pi = data;
      RegLpFb:     k_lp_fb = data;
      RegLpIn:     k_lp_in = data;
      RegLpPrevIn: k_lp_pi = data;
      default: ;
    endcase
  endtask

  task automatic write_all_coefs(logic [CfgDataW-1:0] data);
    write_reg(RegHpFb, data);
    write_reg(RegHpIn, data);
    write_reg(RegHpPrevIn, data);
    write_reg(RegLpFb, data);
    write_reg(RegLpIn, data);
    write_reg(RegLpPrevIn, data);
  endtask

  // Everything sent, taken and checked; the sequencer is back at idle
  task automatic wait_idle();
    while (frames_to_send.size() != 0 || in_if.valid || awaited_frames.size() != 0)
      @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic queue_frame(sample_t l, sample_t r, logic e);
    frame_t f;
    f.left      = l;
    f.right     = r;
    f.block_end = e;
    frames_to_send.push_back(f);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return sample_t'($urandom_range(0, 4095)) - 32'sd2048;
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return CfgDataW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_frames(int count);
    repeat (count) queue_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
  endtask

  // Mostly short lines so echoes come back quickly; zero, full and
  // over-range lengths turn up now and then. Top data bits are junk.
  task automatic random_settings();
    logic [CfgDataW-1:0] len_word;
    case ($urandom_range(0, 11))
      0:       len_word = {3'($urandom()), 13'd0};
      1:       len_word = 16'h1000;
      2:       len_word = {3'($urandom()), 13'($urandom_range(4097, 8191))};
      3:       len_word = 16'd1;
      default: len_word = {3'($urandom()), 13'($urandom_range(1, 48))};
    endcase
    write_reg(RegDelayLen, len_word);
    write_reg(RegHpFb, rand_coef());
    write_reg(RegHpIn, rand_coef());
    write_reg(RegHpPrevIn, rand_coef());
    write_reg(RegLpFb, rand_coef());
    write_reg(RegLpIn, rand_coef());
    write_reg(RegLpPrevIn, rand_coef());
    if ($urandom_range(0, 3) == 0) write_reg(RegNone, CfgDataW'($urandom()));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid     = 1'b0;
    in_if.left_in   = '0;
    in_if.right_in  = '0;
    in_if.block_end = 1'b0;
    out_if.ready    = 1'b0;
    for (int i = 0; i < DelayDepth; i++) mid_line[i] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: sample extremes through a two-frame delay with mild filters.
    // These sit in the queue through the clearing pass.
    write_reg(RegDelayLen, 16'h0002);
    write_reg(RegHpFb, 16'h0200);
    write_reg(RegHpIn, 16'h0400);
    write_reg(RegHpPrevIn, 16'hFC00);
    write_reg(RegLpFb, 16'h0100);
    write_reg(RegLpIn, 16'h0300);
    write_reg(RegLpPrevIn, 16'h0200);
    queue_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    queue_frame(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    queue_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    queue_frame(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    queue_frame(32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1);
    queue_frame(32'sh1234_5678, 32'shEDCB_A987, 1'b0);
    wait_idle();

    // Zero length (with the unused top data bits set) acts as a length of one
    write_reg(RegDelayLen, 16'hE000);
    send_frames(3);
    wait_idle();

    // Most negative coefficients, and a write to the unused index
    write_all_coefs(16'h8000);
    write_reg(RegNone, 16'hFFFF);
    queue_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    queue_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    wait_idle();

    // Most positive coefficients
    write_all_coefs(16'h7FFF);
    queue_frame(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    queue_frame(32'sh7FFF_FFFF, 32'sh0000_0001, 1'b0);
    wait_idle();

    // Position is at slot 0 here; walk it to 9, then cut the length to 3 so the
    // current slot is used once more before the position wraps
    write_reg(RegDelayLen, 16'h0010);
    send_frames(9);
    wait_idle();
    write_reg(RegDelayLen, 16'h0003);
    send_frames(3);
    wait_idle();

    // Random phases with fresh settings each time
    for (int p = 0; p < 11; p++) begin
      random_settings();
      send_frames($urandom_range(100, 150));
      wait_idle();
    end

    // Let any late output beat show up before the verdict
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
